>>> rtl/core/dvrt_pkg.sv
// Shared types and constants for the distance-vector route table core.
// Depends on nothing; every other file in rtl/core imports it.
`timescale 1ns / 1ps

package dvrt_pkg;

  localparam int COST_W         = 10;
  localparam int PORT_NODES     = 4;
  localparam int NODE_COUNT_DEF = 4;
  localparam int CFG_IDX_W      = 3;

  localparam logic [COST_W-1:0] COST_INF = 10'd999;

  // Command codes carried in the cmd field.
  localparam logic [1:0] CMD_INIT   = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_LINK   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd5;

  typedef logic [COST_W-1:0] cost_t;
  typedef cost_t [PORT_NODES-1:0] cost_vec_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] peer_node;
    cost_t      adv_cost_0;
    cost_t      adv_cost_1;
    cost_t      adv_cost_2;
    cost_t      adv_cost_3;
    cost_t      new_link_cost;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] source_node;
    logic [1:0] dest_node;
    cost_t      least_cost_0;
    cost_t      least_cost_1;
    cost_t      least_cost_2;
    cost_t      least_cost_3;
    logic       last_packet;
  } out_beat_t;

  // Sequencer to transmitter: start a broadcast of the given least costs.
  typedef struct packed {
    logic      go;
    cost_vec_t least;
  } bcast_req_t;

endpackage

>>> rtl/core/dvrt_table_mem.sv
// Cost table storage: one write port, one read port, registered read data.
// Depends on dvrt_pkg for the cost width.
`timescale 1ns / 1ps

module dvrt_table_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  dvrt_pkg::cost_t      wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output dvrt_pkg::cost_t      rd_data
);
  import dvrt_pkg::*;

  cost_t mem [DEPTH];
  cost_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/dvrt_seq.sv
// Command sequencer: clears and loads the cost table, or rewrites a column
// and recomputes the least costs. Depends on dvrt_pkg; drives dvrt_table_mem.
`timescale 1ns / 1ps

module dvrt_seq #(
  parameter int NODE_COUNT = dvrt_pkg::NODE_COUNT_DEF,
  parameter int AW         = $clog2(NODE_COUNT * NODE_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_go,
  input  dvrt_pkg::in_beat_t    in_beat,
  input  dvrt_pkg::cost_vec_t   link_cost,
  output logic                  seq_busy,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output dvrt_pkg::cost_t       mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  dvrt_pkg::cost_t       mem_rdata,
  output dvrt_pkg::bcast_req_t  bcast
);
  import dvrt_pkg::*;

  localparam int NW    = $clog2(NODE_COUNT);
  localparam int DEPTH = NODE_COUNT * NODE_COUNT;

  localparam logic [NW-1:0] LAST_IDX    = NW'(NODE_COUNT - 1);
  localparam logic [AW-1:0] LAST_ADDR   = AW'(DEPTH - 1);
  localparam logic [AW-1:0] STRIDE      = AW'(NODE_COUNT);
  localparam logic [AW-1:0] DIAG_STRIDE = AW'(NODE_COUNT + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_DIAG,
    S_COL,
    S_RECOMP
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [NW-1:0]   d_r, d_nxt;
  logic [NW-1:0]   v_r, v_nxt;
  logic            iss_r, iss_nxt;
  logic            p_valid_r, p_valid_nxt;
  logic [NW-1:0]   p_d_r, p_d_nxt;
  logic [NW-1:0]   p_v_r, p_v_nxt;
  logic            changed_r, changed_nxt;
  cost_t           min_r, min_nxt;
  cost_t           least_r [NODE_COUNT];
  cost_t           least_nxt [NODE_COUNT];
  logic [1:0]      cmd_r, cmd_nxt;
  cost_vec_t       adv_r, adv_nxt;
  cost_t           nl_r, nl_nxt;
  cost_t           diag_r, diag_nxt;

  logic            peer_ok;
  logic [NW-1:0]   peer_ix;
  logic [AW-1:0]   diag_addr;
  cost_t           lc_sel;
  cost_t           lc_sat;
  cost_t           adv_sel;
  logic [COST_W:0] upd_sum;
  cost_t           upd_val;
  logic signed [COST_W+1:0] lnk_sum;
  cost_t           lnk_val;
  cost_t           cur_min;
  logic            row_changed;
  logic            bcast_go;
  cost_vec_t       bcast_least;

  assign peer_ok   = (int'(in_beat.peer_node) < NODE_COUNT);
  assign peer_ix   = NW'(in_beat.peer_node);
  assign diag_addr = AW'(peer_ix) * DIAG_STRIDE;

  // Initial diagonal value for row d_r, saturated; rows past the link
  // registers have no link.
  assign lc_sel = (int'(d_r) < PORT_NODES) ? link_cost[2'(d_r)] : COST_INF;
  assign lc_sat = (lc_sel > COST_INF) ? COST_INF : lc_sel;

  assign adv_sel = (int'(d_r) < PORT_NODES) ? adv_r[2'(d_r)] : COST_INF;
  assign upd_sum = {1'b0, diag_r} + {1'b0, adv_sel};
  assign upd_val = (upd_sum > {1'b0, COST_INF}) ? COST_INF : upd_sum[COST_W-1:0];

  // Link change: shift the entry by the difference between new and old link.
  assign lnk_sum = $signed({2'b00, nl_r}) + $signed({2'b00, mem_rdata})
                 - $signed({2'b00, diag_r});
  always_comb begin
    if (lnk_sum < 0) begin
      lnk_val = '0;
    end else if (lnk_sum > $signed({2'b00, COST_INF})) begin
      lnk_val = COST_INF;
    end else begin
      lnk_val = lnk_sum[COST_W-1:0];
    end
  end

  assign cur_min = (p_v_r == '0 || mem_rdata < min_r) ? mem_rdata : min_r;
  assign row_changed = (cur_min != least_r[p_d_r]);

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    d_nxt       = d_r;
    v_nxt       = v_r;
    iss_nxt     = iss_r;
    p_valid_nxt = 1'b0;
    p_d_nxt     = p_d_r;
    p_v_nxt     = p_v_r;
    changed_nxt = changed_r;
    min_nxt     = min_r;
    least_nxt   = least_r;
    cmd_nxt     = cmd_r;
    adv_nxt     = adv_r;
    nl_nxt      = nl_r;
    diag_nxt    = diag_r;
    mem_we      = 1'b0;
    mem_waddr   = addr_r;
    mem_wdata   = COST_INF;
    mem_re      = 1'b0;
    mem_raddr   = addr_r;
    bcast_go    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_go) begin
          cmd_nxt = in_beat.cmd;
          adv_nxt = {in_beat.adv_cost_3, in_beat.adv_cost_2,
                     in_beat.adv_cost_1, in_beat.adv_cost_0};
          nl_nxt  = in_beat.new_link_cost;
          unique case (in_beat.cmd) inside
            CMD_INIT: begin
              addr_nxt  = '0;
              d_nxt     = '0;
              v_nxt     = '0;
              state_nxt = S_INIT;
            end
            CMD_UPDATE, CMD_LINK: begin
              if (peer_ok) begin
                mem_re    = 1'b1;
                mem_raddr = diag_addr;
                addr_nxt  = AW'(peer_ix);
                d_nxt     = '0;
                state_nxt = S_DIAG;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INIT: begin
        mem_we = 1'b1;
        if (d_r == v_r) begin
          mem_wdata      = lc_sat;
          least_nxt[d_r] = lc_sat;
        end
        if (v_r == LAST_IDX) begin
          v_nxt = '0;
          d_nxt = d_r + 1'b1;
        end else begin
          v_nxt = v_r + 1'b1;
        end
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
          bcast_go  = 1'b1;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      S_DIAG: begin
        diag_nxt  = mem_rdata;
        mem_re    = 1'b1;
        state_nxt = S_COL;
      end

      S_COL: begin
        mem_we    = 1'b1;
        mem_wdata = (cmd_r == CMD_LINK) ? lnk_val : upd_val;
        if (d_r == LAST_IDX) begin
          addr_nxt    = '0;
          d_nxt       = '0;
          v_nxt       = '0;
          iss_nxt     = 1'b1;
          changed_nxt = 1'b0;
          state_nxt   = S_RECOMP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = addr_r + STRIDE;
          addr_nxt  = addr_r + STRIDE;
          d_nxt     = d_r + 1'b1;
        end
      end

      S_RECOMP: begin
        if (iss_r) begin
          mem_re      = 1'b1;
          p_valid_nxt = 1'b1;
          p_d_nxt     = d_r;
          p_v_nxt     = v_r;
          if (v_r == LAST_IDX) begin
            v_nxt = '0;
            d_nxt = d_r + 1'b1;
          end else begin
            v_nxt = v_r + 1'b1;
          end
          if (addr_r == LAST_ADDR) begin
            iss_nxt  = 1'b0;
            addr_nxt = '0;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
        if (p_valid_r) begin
          min_nxt = cur_min;
          if (p_v_r == LAST_IDX) begin
            least_nxt[p_d_r] = cur_min;
            if (row_changed) begin
              changed_nxt = 1'b1;
            end
            if (p_d_r == LAST_IDX) begin
              state_nxt = S_IDLE;
              bcast_go  = changed_r | row_changed;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      addr_r    <= '0;
      d_r       <= '0;
      v_r       <= '0;
      iss_r     <= 1'b0;
      p_valid_r <= 1'b0;
      p_d_r     <= '0;
      p_v_r     <= '0;
      changed_r <= 1'b0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        least_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      d_r       <= d_nxt;
      v_r       <= v_nxt;
      iss_r     <= iss_nxt;
      p_valid_r <= p_valid_nxt;
      p_d_r     <= p_d_nxt;
      p_v_r     <= p_v_nxt;
      changed_r <= changed_nxt;
      least_r   <= least_nxt;
    end
    min_r  <= min_nxt;
    cmd_r  <= cmd_nxt;
    adv_r  <= adv_nxt;
    nl_r   <= nl_nxt;
    diag_r <= diag_nxt;
  end

  assign seq_busy = (state_r != S_IDLE);

  // Least-cost vector as carried in a packet; absent nodes read as no route.
  for (genvar i = 0; i < PORT_NODES; i++) begin : g_least
    if (i < NODE_COUNT) begin : g_have
      assign bcast_least[i] = least_r[i];
    end else begin : g_none
      assign bcast_least[i] = COST_INF;
    end
  end

  assign bcast = {bcast_go, bcast_least};

endmodule

>>> rtl/core/dvrt_tx.sv
// Broadcast transmitter: sends the least-cost vector to each enabled
// neighbour, one beat per cycle. Depends on dvrt_pkg.
`timescale 1ns / 1ps

module dvrt_tx #(
  parameter int NODE_COUNT = dvrt_pkg::NODE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dvrt_pkg::bcast_req_t  bcast,
  input  logic [1:0]            own_node_id,
  input  logic [3:0]            neighbor_mask,
  output logic                  tx_busy,
  output logic                  out_valid,
  output dvrt_pkg::out_beat_t   out_beat
);
  import dvrt_pkg::*;

  logic [PORT_NODES-1:0] elig;
  logic [PORT_NODES-1:0] pend_r, pend_nxt;
  logic [PORT_NODES-1:0] low;
  logic [1:0]            dest;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_beat_r, out_beat_nxt;

  // A node receives a copy if it exists, its mask bit is set and it is not us.
  always_comb begin
    for (int i = 0; i < PORT_NODES; i++) begin
      elig[i] = (i < NODE_COUNT) && neighbor_mask[i] && (own_node_id != 2'(i));
    end
  end

  assign low = pend_r & (~pend_r + 1'b1);

  always_comb begin
    dest = '0;
    for (int i = PORT_NODES - 1; i >= 0; i--) begin
      if (low[i]) begin
        dest = 2'(i);
      end
    end
  end

  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_beat_nxt  = out_beat_r;
    if (bcast.go) begin
      pend_nxt = elig;
    end else if (pend_r != '0) begin
      pend_nxt                  = pend_r & ~low;
      out_valid_nxt             = 1'b1;
      out_beat_nxt.source_node  = own_node_id;
      out_beat_nxt.dest_node    = dest;
      out_beat_nxt.least_cost_0 = bcast.least[0];
      out_beat_nxt.least_cost_1 = bcast.least[1];
      out_beat_nxt.least_cost_2 = bcast.least[2];
      out_beat_nxt.least_cost_3 = bcast.least[3];
      out_beat_nxt.last_packet  = ((pend_r & ~low) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_beat_r <= out_beat_nxt;
  end

  assign tx_busy   = (pend_r != '0);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

>>> rtl/core/distance_vector_route_table_core.sv
// Top level of the distance-vector route table core: configuration
// registers and the wiring of dvrt_seq, dvrt_table_mem and dvrt_tx.
// Depends on dvrt_pkg and the three modules named above.
`timescale 1ns / 1ps

// A command beat is taken on a rising edge with start high and busy low,
// and busy stays high until the final packet it causes is on the result
// ports; that packet is there in the first cycle with busy low. Packets
// appear on out_beat for exactly one cycle each, flagged by out_valid, and
// the receiver cannot hold them off, so it must take every beat as it
// comes; out_beat.last_packet marks the final packet of a broadcast. After
// reset the core sets every table entry to infinity (999), with busy high;
// configuration writes are taken during that time as always. The cost
// table lives in one memory with a single read port and a single write
// port, and the sequencer works through it one entry at a time: an init
// command writes every entry of the table in turn. A neighbour update or
// link change reads the diagonal entry, rewrites the peer's column one row
// at a time, then reads the full table entry by entry to find each row's
// minimum, with busy high throughout. A broadcast then sends one packet to
// each eligible neighbour, at most three. A command 3, or a peer beyond the
// node count, is dropped and leaves busy low. Configuration must be written
// only while busy is low; the core itself does not enforce this.

module distance_vector_route_table_core #(
  parameter int NODE_COUNT = dvrt_pkg::NODE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  dvrt_pkg::in_beat_t                in_beat,
  output logic                              out_valid,
  output dvrt_pkg::out_beat_t               out_beat,
  input  logic                              cfg_we,
  input  logic [dvrt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dvrt_pkg::COST_W-1:0]       cfg_wdata
);
  import dvrt_pkg::*;

  localparam int DEPTH = NODE_COUNT * NODE_COUNT;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers, reset to the default topology.
  logic [1:0] own_id_r;
  cost_vec_t  link_cost_r;
  logic [3:0] mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r       <= 2'd1;
      link_cost_r[0] <= 10'd1;
      link_cost_r[1] <= 10'd0;
      link_cost_r[2] <= 10'd1;
      link_cost_r[3] <= COST_INF;
      mask_r         <= 4'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_ID: own_id_r       <= cfg_wdata[1:0];
        REG_LINK_0: link_cost_r[0] <= cfg_wdata;
        REG_LINK_1: link_cost_r[1] <= cfg_wdata;
        REG_LINK_2: link_cost_r[2] <= cfg_wdata;
        REG_LINK_3: link_cost_r[3] <= cfg_wdata;
        REG_MASK:   mask_r         <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  logic          seq_busy;
  logic          tx_busy;
  logic          in_go;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cost_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  cost_t         mem_rdata;
  bcast_req_t    bcast;

  // The sequencer holds busy up to the cycle in which it hands a broadcast
  // over, and the transmitter holds it from the next cycle, so there is no
  // gap in which a new command could slip in.
  assign busy  = seq_busy | tx_busy;
  assign in_go = start & ~busy;

  dvrt_seq #(
    .NODE_COUNT (NODE_COUNT),
    .AW         (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_go     (in_go),
    .in_beat   (in_beat),
    .link_cost (link_cost_r),
    .seq_busy  (seq_busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .bcast     (bcast)
  );

  dvrt_table_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  dvrt_tx #(
    .NODE_COUNT (NODE_COUNT)
  ) u_tx (
    .clk           (clk),
    .rst_n         (rst_n),
    .bcast         (bcast),
    .own_node_id   (own_id_r),
    .neighbor_mask (mask_r),
    .tx_busy       (tx_busy),
    .out_valid     (out_valid),
    .out_beat      (out_beat)
  );

endmodule
